>>> hw/rtl/dvl_pkg.sv
package dvl_pkg;

    localparam int VW  = 30;
    localparam int AW  = VW - 1;
    localparam int RW  = 2 * VW;
    localparam int MW  = VW;
    localparam int NW  = AW + 15;
    localparam int DRW = NW + 2;
    localparam int QW  = 15;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_D_IND = 3'd0;
    localparam reg_idx_t REG_Q_IND = 3'd1;
    localparam reg_idx_t REG_FLUX  = 3'd2;
    localparam reg_idx_t REG_POLES = 3'd3;
    localparam reg_idx_t REG_LIMIT = 3'd4;

    typedef struct packed {
        logic [15:0] ld;
        logic [15:0] lq;
        logic [15:0] flux;
        logic [4:0]  pp;
        logic [14:0] lim;
    } dvl_cfg_t;

    typedef struct packed {
        logic                 limited;
        logic signed [VW-1:0] vd;
        logic signed [VW-1:0] vq;
    } dvl_pass_t;

    typedef struct packed {
        logic [RW-1:0] rad;
        logic [MW+1:0] rem;
        logic [MW-1:0] root;
        logic [NW-1:0] nd;
        logic [NW-1:0] nq;
        dvl_pass_t     pass;
    } dvl_sqrt_t;

    typedef struct packed {
        logic [MW-1:0]  mag;
        logic [DRW-1:0] rem_d;
        logic [DRW-1:0] rem_q;
        logic [QW-1:0]  quo_d;
        logic [QW-1:0]  quo_q;
        dvl_pass_t      pass;
    } dvl_div_t;

    typedef struct packed {
        logic        limited;
        logic [15:0] vq;
        logic [15:0] vd;
    } dvl_out_t;

endpackage

>>> hw/rtl/dvl_front.sv
module dvl_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [15:0]  vd_feedback,
    input  logic signed [15:0]  vq_feedback,
    input  logic signed [15:0]  d_current,
    input  logic signed [15:0]  q_current,
    input  logic signed [15:0]  mech_speed,
    input  dvl_pkg::dvl_cfg_t   cfg,
    output logic                out_valid,
    output dvl_pkg::dvl_sqrt_t  out_data
);
    import dvl_pkg::*;

    logic [4:0] v_reg, v_next;

    logic signed [21:0] we_reg, we_next;
    logic signed [32:0] lqiq_reg, lqiq_next;
    logic signed [34:0] psi_reg, psi_next;
    logic signed [15:0] vdf1_reg, vqf1_reg, vdf2_reg, vqf2_reg;

    logic signed [54:0] dterm_reg, dterm_next;
    logic signed [56:0] qterm_reg, qterm_next;

    logic signed [54:0] dround;
    logic signed [56:0] qround;
    logic signed [VW-1:0] vd3_reg, vd3_next, vq3_reg, vq3_next;

    logic [AW-1:0] ad, aq;
    logic [2*AW-1:0] sqd_reg, sqd_next, sqq_reg, sqq_next;
    logic [NW-1:0] nd_reg, nd_next, nq_reg, nq_next;
    logic [29:0] lsq_reg, lsq_next;
    logic signed [VW-1:0] vd4_reg, vq4_reg;

    logic [RW-1:0] s_sum;
    dvl_sqrt_t s5_reg, s5_next;

    assign v_next = {v_reg[3:0], in_valid};

    // electrical speed and flux products
    assign we_next   = $signed({1'b0, cfg.pp}) * mech_speed;
    assign lqiq_next = $signed({1'b0, cfg.lq}) * q_current;
    assign psi_next  = $signed({1'b0, cfg.ld}) * d_current + $signed({3'b0, cfg.flux, 16'b0});

    // cross-coupling terms
    assign dterm_next = we_reg * lqiq_reg;
    assign qterm_next = we_reg * psi_reg;

    // round half up, then add feedback
    assign dround   = dterm_reg + 55'sd8388608;
    assign qround   = qterm_reg + 57'sd8388608;
    assign vd3_next = {{(VW-16){vdf2_reg[15]}}, vdf2_reg} - dround[53:24];
    assign vq3_next = {{(VW-16){vqf2_reg[15]}}, vqf2_reg} + qround[53:24];

    // squares and limit numerators
    assign ad       = vd3_reg[VW-1] ? AW'(-vd3_reg) : AW'(vd3_reg);
    assign aq       = vq3_reg[VW-1] ? AW'(-vq3_reg) : AW'(vq3_reg);
    assign sqd_next = ad * ad;
    assign sqq_next = aq * aq;
    assign nd_next  = ad * cfg.lim;
    assign nq_next  = aq * cfg.lim;
    assign lsq_next = cfg.lim * cfg.lim;

    assign s_sum = RW'(sqd_reg) + RW'(sqq_reg);
    always_comb begin
        s5_next              = '0;
        s5_next.rad          = s_sum;
        s5_next.nd           = nd_reg;
        s5_next.nq           = nq_reg;
        s5_next.pass.limited = s_sum > RW'(lsq_reg);
        s5_next.pass.vd      = vd4_reg;
        s5_next.pass.vq      = vq4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            we_reg    <= we_next;
            lqiq_reg  <= lqiq_next;
            psi_reg   <= psi_next;
            vdf1_reg  <= vd_feedback;
            vqf1_reg  <= vq_feedback;
            dterm_reg <= dterm_next;
            qterm_reg <= qterm_next;
            vdf2_reg  <= vdf1_reg;
            vqf2_reg  <= vqf1_reg;
            vd3_reg   <= vd3_next;
            vq3_reg   <= vq3_next;
            sqd_reg   <= sqd_next;
            sqq_reg   <= sqq_next;
            nd_reg    <= nd_next;
            nq_reg    <= nq_next;
            lsq_reg   <= lsq_next;
            vd4_reg   <= vd3_reg;
            vq4_reg   <= vq3_reg;
            s5_reg    <= s5_next;
        end
    end

    assign out_valid = v_reg[4];
    assign out_data  = s5_reg;

endmodule

>>> hw/rtl/dvl_sqrt_cell.sv
module dvl_sqrt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  dvl_pkg::dvl_sqrt_t in_data,
    output logic               out_valid,
    output dvl_pkg::dvl_sqrt_t out_data
);
    import dvl_pkg::*;

    logic      v_reg;
    dvl_sqrt_t d_reg, d_next;
    logic [MW+3:0] cand, trial;
    logic          ge;

    // one root bit per cell
    assign cand  = {in_data.rem, in_data.rad[RW-1 -: 2]};
    assign trial = {2'b0, in_data.root, 2'b01};
    assign ge    = cand >= trial;

    always_comb begin
        d_next      = in_data;
        d_next.rad  = {in_data.rad[RW-3:0], 2'b00};
        d_next.rem  = ge ? (MW+2)'(cand - trial) : (MW+2)'(cand);
        d_next.root = {in_data.root[MW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

>>> hw/rtl/dvl_div_cell.sv
module dvl_div_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  dvl_pkg::dvl_div_t in_data,
    output logic              out_valid,
    output dvl_pkg::dvl_div_t out_data
);
    import dvl_pkg::*;

    logic           v_reg;
    dvl_div_t       d_reg, d_next;
    logic [DRW-1:0] dsh;
    logic           ge_d, ge_q;
    logic [DRW-1:0] rd, rq;

    // one quotient bit per cell on each axis
    assign dsh  = {2'b0, in_data.mag, {(QW-1){1'b0}}};
    assign ge_d = in_data.rem_d >= dsh;
    assign ge_q = in_data.rem_q >= dsh;
    assign rd   = ge_d ? in_data.rem_d - dsh : in_data.rem_d;
    assign rq   = ge_q ? in_data.rem_q - dsh : in_data.rem_q;

    always_comb begin
        d_next       = in_data;
        d_next.rem_d = {rd[DRW-2:0], 1'b0};
        d_next.rem_q = {rq[DRW-2:0], 1'b0};
        d_next.quo_d = {in_data.quo_d[QW-2:0], ge_d};
        d_next.quo_q = {in_data.quo_q[QW-2:0], ge_q};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

>>> hw/rtl/dq_voltage_decouple_and_limit_unit.sv
// dq voltage decoupling with a circular voltage limit
// s_ channel: one word per control sample (feedback voltages, dq currents,
// mechanical speed). m_ channel: limited vd/vq commands, m_tuser flags a
// vector that was scaled down to the limit. One result word per input word.
// Parameters sit on the APB port: 0 d inductance, 4 q inductance, 8 flux,
// 12 pole pairs, 16 voltage limit; write them only while the block is idle.
// A word passes through the whole row of cells before m_tvalid rises. The row holds
// 5 front stages (speed, cross-coupling products, rounding, squares, sum),
// 30 square-root cells (one root bit each), 15 divider cells (one quotient
// bit per axis each) and the output register; the first front stage loads
// at the accepting edge. Throughput: one word per cycle while s_tready is high.
// When m_tready is low the result waits in the output register and the next
// one goes into a skid register; only then does s_tready drop, and the whole
// row of cells holds until the skid register drains.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// parameter reset values: no result is produced for words still in flight.
module dq_voltage_decouple_and_limit_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // vd_feedback, vq_feedback, d_current, q_current, mech_speed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // vd_command, vq_command
    output logic [0:0]  m_tuser,   // was_limited
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dvl_pkg::*;

    localparam int NSQ = MW;
    localparam int NDV = QW;

    dvl_cfg_t cfg_reg, cfg_next;
    reg_idx_t idx;
    logic     wr;

    logic      en;
    logic      sq_v  [0:NSQ];
    dvl_sqrt_t sq_bus[0:NSQ];
    logic      dv_v  [0:NDV];
    dvl_div_t  dv_bus[0:NDV];
    dvl_div_t  div_in;

    dvl_div_t last;
    dvl_out_t res;
    logic [QW:0] qd_ext, qq_ext;

    logic     m_v_reg, m_v_next, k_v_reg, k_v_next;
    dvl_out_t m_d_reg, m_d_next, k_d_reg, k_d_next;
    logic     arrive;

    // apb registers
    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            unique case (idx)
                REG_D_IND: cfg_next.ld   = pwdata[15:0];
                REG_Q_IND: cfg_next.lq   = pwdata[15:0];
                REG_FLUX:  cfg_next.flux = pwdata[15:0];
                REG_POLES: cfg_next.pp   = pwdata[4:0];
                REG_LIMIT: cfg_next.lim  = pwdata[14:0];
                default:   cfg_next      = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_D_IND: prdata = {16'b0, cfg_reg.ld};
            REG_Q_IND: prdata = {16'b0, cfg_reg.lq};
            REG_FLUX:  prdata = {16'b0, cfg_reg.flux};
            REG_POLES: prdata = {27'b0, cfg_reg.pp};
            REG_LIMIT: prdata = {17'b0, cfg_reg.lim};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ld   <= 16'd4698;
            cfg_reg.lq   <= 16'd5033;
            cfg_reg.flux <= 16'd1049;
            cfg_reg.pp   <= 5'd7;
            cfg_reg.lim  <= 15'd9216;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // datapath
    assign en       = !k_v_reg;
    assign s_tready = en;

    dvl_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .vd_feedback ($signed(s_tdata[15:0])),
        .vq_feedback ($signed(s_tdata[31:16])),
        .d_current   ($signed(s_tdata[47:32])),
        .q_current   ($signed(s_tdata[63:48])),
        .mech_speed  ($signed(s_tdata[79:64])),
        .cfg         (cfg_reg),
        .out_valid   (sq_v[0]),
        .out_data    (sq_bus[0])
    );

    for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
        dvl_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_v[i]),
            .in_data   (sq_bus[i]),
            .out_valid (sq_v[i+1]),
            .out_data  (sq_bus[i+1])
        );
    end

    always_comb begin
        div_in       = '0;
        div_in.mag   = sq_bus[NSQ].root;
        div_in.rem_d = {2'b0, sq_bus[NSQ].nd};
        div_in.rem_q = {2'b0, sq_bus[NSQ].nq};
        div_in.pass  = sq_bus[NSQ].pass;
    end

    assign dv_v[0]   = sq_v[NSQ];
    assign dv_bus[0] = div_in;

    for (genvar j = 0; j < NDV; j++) begin : g_div
        dvl_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[j]),
            .in_data   (dv_bus[j]),
            .out_valid (dv_v[j+1]),
            .out_data  (dv_bus[j+1])
        );
    end

    // sign restore and saturation
    assign last   = dv_bus[NDV];
    assign qd_ext = {1'b0, last.quo_d};
    assign qq_ext = {1'b0, last.quo_q};

    always_comb begin
        res.limited = last.pass.limited;
        if (last.pass.limited) begin
            res.vd = last.pass.vd[VW-1] ? 16'(-qd_ext) : qd_ext;
            res.vq = last.pass.vq[VW-1] ? 16'(-qq_ext) : qq_ext;
        end else begin
            if (last.pass.vd > VW'(32767)) begin
                res.vd = 16'h7fff;
            end else if (last.pass.vd < -VW'(32768)) begin
                res.vd = 16'h8000;
            end else begin
                res.vd = last.pass.vd[15:0];
            end
            if (last.pass.vq > VW'(32767)) begin
                res.vq = 16'h7fff;
            end else if (last.pass.vq < -VW'(32768)) begin
                res.vq = 16'h8000;
            end else begin
                res.vq = last.pass.vq[15:0];
            end
        end
    end

    // output register with skid
    assign arrive = en && dv_v[NDV];

    always_comb begin
        m_v_next = m_v_reg;
        m_d_next = m_d_reg;
        k_v_next = k_v_reg;
        k_d_next = k_d_reg;
        if (m_tready || !m_v_reg) begin
            if (k_v_reg) begin
                m_v_next = 1'b1;
                m_d_next = k_d_reg;
                k_v_next = 1'b0;
            end else begin
                m_v_next = arrive;
                m_d_next = res;
            end
        end else if (arrive) begin
            k_v_next = 1'b1;
            k_d_next = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg <= 1'b0;
            k_v_reg <= 1'b0;
        end else begin
            m_v_reg <= m_v_next;
            k_v_reg <= k_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_d_reg <= m_d_next;
        k_d_reg <= k_d_next;
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = {m_d_reg.vq, m_d_reg.vd};
    assign m_tuser  = m_d_reg.limited;

endmodule

>>> hw/rtl/dvl_checker.sv
module dvl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        pready
);

    a_rst_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output stall");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("apb wait state");

endmodule

bind dq_voltage_decouple_and_limit_unit dvl_checker u_dvl_checker (.*);

>>> sim/dq_voltage_decouple_and_limit_unit_tb.sv
`timescale 1ns / 100ps

module dq_voltage_decouple_and_limit_unit_tb;
    import dvl_pkg::*;

    typedef struct packed {
        logic        limited;
        logic [15:0] vq;
        logic [15:0] vd;
    } cmd_t;

    class cmd_scoreboard;
        cmd_t         pending[$];
        int           errors;
        logic [15:0]  ld, lq, flux;
        logic [4:0]   pp;
        logic [14:0]  lim;

        function void set_reset_values();
            ld = 16'd4698; lq = 16'd5033; flux = 16'd1049; pp = 5'd7; lim = 15'd9216;
            errors = 0;
        endfunction

        function longint rnd24(longint x);
            return (x + (64'sd1 <<< 23)) >>> 24;
        endfunction

        function longint isqrt(longint s);
            longint r, b;
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > s) b = b >>> 2;
            while (b != 0) begin
                if (s >= r + b) begin
                    s = s - (r + b);
                    r = (r >>> 1) + b;
                end else begin
                    r = r >>> 1;
                end
                b = b >>> 2;
            end
            return r;
        endfunction

        function longint scale(longint v, longint m);
            longint q;
            q = ((v < 0 ? -v : v) * longint'(lim)) / m;
            return v < 0 ? -q : q;
        endfunction

        function logic [15:0] sat(longint x);
            if (x > 32767) return 16'h7fff;
            if (x < -32768) return 16'h8000;
            return x[15:0];
        endfunction

        function void note_input(logic [79:0] w);
            longint vdf, vqf, id, iq, spd, we, vd, vq, s, m;
            cmd_t   c;
            vdf = longint'($signed(w[15:0]));
            vqf = longint'($signed(w[31:16]));
            id  = longint'($signed(w[47:32]));
            iq  = longint'($signed(w[63:48]));
            spd = longint'($signed(w[79:64]));
            we  = longint'(pp) * spd;
            vd  = vdf - rnd24(we * longint'(lq) * iq);
            vq  = vqf + rnd24(we * (longint'(ld) * id + (longint'(flux) <<< 16)));
            s   = vd * vd + vq * vq;
            c.limited = 1'b0;
            if (s > longint'(lim) * longint'(lim)) begin
                m  = isqrt(s);
                vd = scale(vd, m);
                vq = scale(vq, m);
                c.limited = 1'b1;
            end
            c.vd = sat(vd);
            c.vq = sat(vq);
            pending.push_back(c);
        endfunction

        function void check_result(logic [31:0] d, logic u);
            cmd_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected word vd=%h vq=%h lim=%b", $time, d[15:0], d[31:16], u);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.vd !== d[15:0]) begin
                $display("%0t vd_command expected %h actual %h", $time, e.vd, d[15:0]);
                errors++;
            end
            if (e.vq !== d[31:16]) begin
                $display("%0t vq_command expected %h actual %h", $time, e.vq, d[31:16]);
                errors++;
            end
            if (e.limited !== u) begin
                $display("%0t was_limited expected %b actual %b", $time, e.limited, u);
                errors++;
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, m_tvalid, m_tready;
    logic [79:0] s_tdata;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    int           send_idle_pct, recv_stall_pct;
    longint       cycles;
    cmd_scoreboard sb;

    dq_voltage_decouple_and_limit_unit uut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 2000000) begin
                $display("dq_voltage_decouple_and_limit_unit regression: fail");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tdata);
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_D_IND: sb.ld   = v[15:0];
            REG_Q_IND: sb.lq   = v[15:0];
            REG_FLUX:  sb.flux = v[15:0];
            REG_POLES: sb.pp   = v[4:0];
            REG_LIMIT: sb.lim  = v[14:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic send_word(logic [79:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [79:0] rand_word(bit realistic);
        logic [79:0] w;
        w = {rand_field(), rand_field(), rand_field(), rand_field(), rand_field()};
        if (realistic) begin
            w[79:64] = 16'($signed($urandom_range(1200)) - 600);
            w[63:48] = 16'($signed($urandom_range(8000)) - 4000);
            w[47:32] = 16'($signed($urandom_range(8000)) - 4000);
            w[31:16] = 16'($signed($urandom_range(16000)) - 8000);
            w[15:0]  = 16'($signed($urandom_range(16000)) - 8000);
        end
        return w;
    endfunction

    initial begin
        logic [79:0] dir[$];
        sb = new();
        sb.set_reset_values();
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: zero vector, extremes, saturation, limit behavior
        dir.push_back('0);
        dir.push_back({16'd0, 16'd0, 16'd0, 16'd100, 16'd200});
        dir.push_back({16'd0, 16'd0, 16'd0, 16'h7fff, 16'h7fff});
        dir.push_back({16'd0, 16'd0, 16'd0, 16'h8000, 16'h8000});
        dir.push_back({16'd0, 16'd0, 16'd0, 16'h8000, 16'h7fff});
        dir.push_back({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        dir.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
        dir.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
        dir.push_back({16'd300, 16'd1000, 16'hfc00, 16'd0, 16'd0});
        dir.push_back({16'd0, 16'd0, 16'd0, 16'd9216, 16'd0});
        dir.push_back({16'd0, 16'd0, 16'd0, 16'd9217, 16'd0});
        foreach (dir[i]) send_word(dir[i]);
        drain();
        write_reg(REG_LIMIT, 32'd0);
        write_reg(REG_POLES, 32'd0);
        send_word({16'd0, 16'd0, 16'd0, 16'd5, 16'hfffb});
        send_word('0);
        send_word({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        drain();
        write_reg(REG_LIMIT, 32'h7fff);
        write_reg(REG_POLES, 32'd31);
        write_reg(REG_D_IND, 32'hffff);
        write_reg(REG_Q_IND, 32'hffff);
        write_reg(REG_FLUX, 32'hffff);
        send_word({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        send_word({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
        send_word({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (ph == 0) begin
                write_reg(REG_D_IND, 32'd4698); write_reg(REG_Q_IND, 32'd5033);
                write_reg(REG_FLUX, 32'd1049);  write_reg(REG_POLES, 32'd7);
                write_reg(REG_LIMIT, 32'd9216);
            end else begin
                write_reg(REG_D_IND, $urandom_range(65535));
                write_reg(REG_Q_IND, $urandom_range(65535));
                write_reg(REG_FLUX, $urandom_range(65535));
                write_reg(REG_POLES, $urandom_range(ph == 6 ? 31 : 16, 1));
                write_reg(REG_LIMIT, ph == 6 ? 32'd1 : $urandom_range(32767));
            end
            for (int n = 0; n < 200; n++) begin
                if (n == 100 && ph == 1) drain();
                send_word(rand_word($urandom_range(99) < 70));
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("dq_voltage_decouple_and_limit_unit regression: pass");
        end else begin
            $display("dq_voltage_decouple_and_limit_unit regression: fail");
        end
        $finish;
    end
endmodule
